>>> src/psup_pkg.sv
// ----------------------------------------------------------------------------
// psup_pkg
// Shared types, state codes and register defaults for the power supervisor.
// ----------------------------------------------------------------------------
package psup_pkg;

    localparam int VS_W       = 3;
    localparam int SEQ_W      = 3;
    localparam int HS_W       = 3;
    localparam int CMD_W      = 2;
    localparam int CNT8_W     = 8;
    localparam int CNT16_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SEQ_W-1:0] SEQ_IDLE      = 3'd0;
    localparam logic [SEQ_W-1:0] SEQ_POWER_ON  = 3'd1;
    localparam logic [SEQ_W-1:0] SEQ_READY     = 3'd2;
    localparam logic [SEQ_W-1:0] SEQ_CONNECTED = 3'd3;
    localparam logic [SEQ_W-1:0] SEQ_POWER_OFF = 3'd4;
    localparam logic [SEQ_W-1:0] SEQ_DEV_OFF   = 3'd5;

    localparam logic [HS_W-1:0] HS_START        = 3'd0;
    localparam logic [HS_W-1:0] HS_WAIT_CONNECT = 3'd1;
    localparam logic [HS_W-1:0] HS_SEND_REQ     = 3'd2;
    localparam logic [HS_W-1:0] HS_WAIT_RESP    = 3'd3;
    localparam logic [HS_W-1:0] HS_DONE         = 3'd4;
    localparam logic [HS_W-1:0] HS_ERROR        = 3'd5;
    localparam logic [HS_W-1:0] HS_FAILED       = 3'd6;

    localparam logic [CMD_W-1:0] PCMD_NONE = 2'd0;
    localparam logic [CMD_W-1:0] PCMD_ON   = 2'd1;
    localparam logic [CMD_W-1:0] PCMD_OFF  = 2'd2;

    localparam logic [CMD_W-1:0] LCMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] LCMD_ENABLE  = 2'd1;
    localparam logic [CMD_W-1:0] LCMD_DISABLE = 2'd2;

    localparam logic [VS_W-1:0] VS_NORMAL   = 3'd0;
    localparam logic [VS_W-1:0] VS_LOW_ABN  = 3'd1;
    localparam logic [VS_W-1:0] VS_HIGH_ABN = 3'd3;
    localparam logic [VS_W-1:0] VS_HIGH     = 3'd4;

    localparam logic [CNT8_W-1:0] FAILED_MARK = 8'd209;
    localparam logic [CNT8_W-1:0] CNT8_MAX    = 8'hFF;
    localparam logic [CNT16_W-1:0] CNT16_MAX  = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CONNECT_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIMEOUT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT            = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_DEBOUNCE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_VOLTAGE_DEBOUNCE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_WARN_COUNT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_TIMEOUT_COUNT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_ENABLE        = 3'd7;

    typedef struct packed {
        logic [CNT16_W-1:0] first_connect_timeout;
        logic [CNT16_W-1:0] response_timeout;
        logic [CNT8_W-1:0]  retry_limit;
        logic [CNT8_W-1:0]  voltage_debounce;
        logic [CNT8_W-1:0]  high_voltage_debounce;
        logic [CNT16_W-1:0] watchdog_warn_count;
        logic [CNT16_W-1:0] watchdog_timeout_count;
        logic               watchdog_enable;
    } cfg_t;

    localparam cfg_t CFG_DEFAULT = '{
        first_connect_timeout:  16'd250,
        response_timeout:       16'd100,
        retry_limit:            8'd3,
        voltage_debounce:       8'd25,
        high_voltage_debounce:  8'd25,
        watchdog_warn_count:    16'd100,
        watchdog_timeout_count: 16'd250,
        watchdog_enable:        1'b1
    };

    typedef struct packed {
        logic [VS_W-1:0] voltage_status;
        logic            sleep_request;
        logic            off_request;
        logic            device_power_feedback;
        logic            first_connect_event;
        logic            power_up_event;
        logic            watchdog_pin;
        logic            processor_powered;
        logic            test_mode_normal;
    } in_word_t;

    typedef struct packed {
        logic [SEQ_W-1:0] sequencer_state;
        logic [HS_W-1:0]  handshake_state;
        logic             link_connected;
        logic             power_allowed;
        logic             link_allowed;
        logic [CMD_W-1:0] power_command;
        logic [CMD_W-1:0] link_command;
        logic             shutdown_pulse;
        logic             reinit_pulse;
        logic             link_error;
        logic             soft_reset_request;
    } out_word_t;

    typedef struct packed {
        logic step;
        logic tick;
    } hs_ctrl_t;

    typedef struct packed {
        logic step;
        logic service;
        logic clear;
    } wd_ctrl_t;

endpackage

>>> src/soc_power_supervisor_top.sv
// ----------------------------------------------------------------------------
// soc_power_supervisor_top
// Power-up supervisor for a companion processor. Each accepted word is one
// tick: supply debounce, power sequencer, connect handshake and watchdog pin
// monitor each advance at most once. A word is accepted every cycle while
// in_stall is low; its result word goes through the input register, then
// one pass of step logic into the result register. Throughput is one word
// per cycle while the result side takes words, since all state updates
// in that single registered step. Configuration registers are written at
// any edge with cfg_we high and take effect on the next tick.
// ----------------------------------------------------------------------------
module soc_power_supervisor_top
    import psup_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data
);

    cfg_t             cfg_reg;
    logic             s1_valid_reg, s1_valid_next;
    in_word_t         s1_data_reg;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             advance, in_take;
    logic             power_allow, link_allow;
    logic [HS_W-1:0]  hs_state, hs_state_next;
    logic             error_next, soft_reset;
    hs_ctrl_t         hs_ctrl;
    wd_ctrl_t         wd_ctrl;
    logic [CMD_W-1:0] pwr_cmd, link_cmd;
    logic             shut, reinit;

    assign advance        = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_DEFAULT;
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_CONNECT_TIMEOUT:  cfg_reg.first_connect_timeout  <= cfg_data;
                CFG_RESPONSE_TIMEOUT:       cfg_reg.response_timeout       <= cfg_data;
                CFG_RETRY_LIMIT:            cfg_reg.retry_limit            <= cfg_data[7:0];
                CFG_VOLTAGE_DEBOUNCE:       cfg_reg.voltage_debounce       <= cfg_data[7:0];
                CFG_HIGH_VOLTAGE_DEBOUNCE:  cfg_reg.high_voltage_debounce  <= cfg_data[7:0];
                CFG_WATCHDOG_WARN_COUNT:    cfg_reg.watchdog_warn_count    <= cfg_data;
                CFG_WATCHDOG_TIMEOUT_COUNT: cfg_reg.watchdog_timeout_count <= cfg_data;
                CFG_WATCHDOG_ENABLE:        cfg_reg.watchdog_enable        <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    psup_debounce u_debounce (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .voltage_status   (s1_data_reg.voltage_status),
        .sleep_request    (s1_data_reg.sleep_request),
        .cfg              (cfg_reg),
        .power_allow_next (power_allow),
        .link_allow_next  (link_allow)
    );

    psup_handshake u_handshake (
        .clk                 (clk),
        .rst_n               (rst_n),
        .ctrl                (hs_ctrl),
        .first_connect_event (s1_data_reg.first_connect_event),
        .power_up_event      (s1_data_reg.power_up_event),
        .cfg                 (cfg_reg),
        .hs_state            (hs_state),
        .hs_state_next       (hs_state_next)
    );

    psup_watchdog u_watchdog (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (wd_ctrl),
        .watchdog_pin      (s1_data_reg.watchdog_pin),
        .processor_powered (s1_data_reg.processor_powered),
        .test_mode_normal  (s1_data_reg.test_mode_normal),
        .voltage_status    (s1_data_reg.voltage_status),
        .cfg               (cfg_reg),
        .error_next        (error_next),
        .soft_reset        (soft_reset)
    );

    always_comb
    begin
        seq_next        = seq_reg;
        pwr_cmd         = PCMD_NONE;
        link_cmd        = LCMD_NONE;
        shut            = 1'b0;
        reinit          = 1'b0;
        hs_ctrl.step    = advance;
        hs_ctrl.tick    = 1'b0;
        wd_ctrl.step    = advance;
        wd_ctrl.service = 1'b0;
        wd_ctrl.clear   = 1'b0;
        case (seq_reg)
            SEQ_IDLE:
            begin
                if (power_allow)
                begin
                    pwr_cmd  = PCMD_ON;
                    seq_next = SEQ_POWER_ON;
                end
                else
                begin
                    wd_ctrl.service = 1'b1;
                    if (s1_data_reg.device_power_feedback)
                        seq_next = SEQ_DEV_OFF;
                    else if (s1_data_reg.off_request)
                        seq_next = SEQ_POWER_OFF;
                end
            end
            SEQ_POWER_ON:
            begin
                if (!power_allow)
                    seq_next = SEQ_DEV_OFF;
                else if (link_allow)
                begin
                    link_cmd = LCMD_ENABLE;
                    seq_next = SEQ_READY;
                end
                else if (s1_data_reg.off_request)
                    seq_next = SEQ_POWER_OFF;
            end
            SEQ_READY, SEQ_CONNECTED:
            begin
                if (!power_allow)
                    seq_next = SEQ_DEV_OFF;
                else if (!link_allow)
                    seq_next = SEQ_POWER_ON;
                else
                begin
                    hs_ctrl.tick    = seq_reg == SEQ_READY;
                    wd_ctrl.service = 1'b1;
                    if (s1_data_reg.off_request)
                        seq_next = SEQ_POWER_OFF;
                    else if (seq_reg == SEQ_READY && hs_state_next == HS_DONE)
                        seq_next = SEQ_CONNECTED;
                end
            end
            SEQ_POWER_OFF:
            begin
                if (s1_data_reg.off_request)
                begin
                    shut = 1'b1;
                    if (!power_allow)
                        seq_next = SEQ_DEV_OFF;
                end
                else
                begin
                    reinit   = 1'b1;
                    seq_next = SEQ_IDLE;
                end
            end
            SEQ_DEV_OFF:
            begin
                wd_ctrl.clear = 1'b1;
                link_cmd      = LCMD_DISABLE;
                pwr_cmd       = PCMD_OFF;
                seq_next      = SEQ_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_data_next.sequencer_state    = seq_next;
        out_data_next.handshake_state    = hs_state_next;
        out_data_next.link_connected     = hs_state == HS_DONE;
        out_data_next.power_allowed      = power_allow;
        out_data_next.link_allowed       = link_allow;
        out_data_next.power_command      = pwr_cmd;
        out_data_next.link_command       = link_cmd;
        out_data_next.shutdown_pulse     = shut;
        out_data_next.reinit_pulse       = reinit;
        out_data_next.link_error         = error_next;
        out_data_next.soft_reset_request = soft_reset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= SEQ_IDLE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                seq_reg <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_power_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.power_command == PCMD_ON)
        |-> (out_data_reg.sequencer_state == SEQ_POWER_ON))
        else $error("power on command outside power on state");

    a_link_enable_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.link_command == LCMD_ENABLE)
        |-> (out_data_reg.sequencer_state == SEQ_READY))
        else $error("link enable command outside ready state");

    a_power_off_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.power_command == PCMD_OFF)
        |-> (out_data_reg.sequencer_state == SEQ_IDLE
             && out_data_reg.link_command == LCMD_DISABLE))
        else $error("device off step without matching commands");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (out_valid_reg && s1_valid_reg))
        else $error("pending word dropped while result stalled");

endmodule

>>> src/psup_debounce.sv
// ----------------------------------------------------------------------------
// psup_debounce
// Supply status debounce into the power and link allow flags.
// ----------------------------------------------------------------------------
module psup_debounce
    import psup_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [VS_W-1:0] voltage_status,
    input  logic            sleep_request,
    input  cfg_t            cfg,
    output logic            power_allow_next,
    output logic            link_allow_next
);

    logic [CNT8_W-1:0] normal_reg, normal_next;
    logic [CNT8_W-1:0] abnormal_reg, abnormal_next;
    logic [CNT8_W-1:0] high_reg, high_next;
    logic              power_allow_reg, link_allow_reg;
    logic [CNT8_W-1:0] normal_inc, abnormal_inc, high_inc;

    assign normal_inc   = (normal_reg == CNT8_MAX) ? CNT8_MAX : normal_reg + 8'd1;
    assign abnormal_inc = (abnormal_reg == CNT8_MAX) ? CNT8_MAX : abnormal_reg + 8'd1;
    assign high_inc     = (high_reg == CNT8_MAX) ? CNT8_MAX : high_reg + 8'd1;

    always_comb
    begin
        normal_next      = normal_reg;
        abnormal_next    = abnormal_reg;
        high_next        = high_reg;
        power_allow_next = power_allow_reg;
        link_allow_next  = link_allow_reg;
        if (voltage_status == VS_NORMAL)
        begin
            normal_next   = normal_inc;
            abnormal_next = '0;
            high_next     = '0;
            if (normal_inc > cfg.voltage_debounce)
            begin
                power_allow_next = !sleep_request;
                link_allow_next  = !sleep_request;
                normal_next      = cfg.voltage_debounce + 8'd1;
            end
        end
        else if (voltage_status inside {[VS_LOW_ABN:VS_HIGH_ABN]})
        begin
            abnormal_next = abnormal_inc;
            normal_next   = '0;
            high_next     = '0;
            if (abnormal_inc > cfg.voltage_debounce)
            begin
                power_allow_next = 1'b0;
                link_allow_next  = 1'b0;
                abnormal_next    = cfg.voltage_debounce + 8'd1;
            end
        end
        else if (voltage_status == VS_HIGH)
        begin
            high_next     = high_inc;
            normal_next   = '0;
            abnormal_next = '0;
            if (high_inc > cfg.high_voltage_debounce)
            begin
                power_allow_next = 1'b0;
                link_allow_next  = 1'b0;
                high_next        = cfg.high_voltage_debounce + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg      <= '0;
            abnormal_reg    <= '0;
            high_reg        <= '0;
            power_allow_reg <= 1'b0;
            link_allow_reg  <= 1'b0;
        end
        else if (step)
        begin
            normal_reg      <= normal_next;
            abnormal_reg    <= abnormal_next;
            high_reg        <= high_next;
            power_allow_reg <= power_allow_next;
            link_allow_reg  <= link_allow_next;
        end
    end

endmodule

>>> src/psup_handshake.sv
// ----------------------------------------------------------------------------
// psup_handshake
// Connect and power up response handshake with timeouts and retry count.
// ----------------------------------------------------------------------------
module psup_handshake
    import psup_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  hs_ctrl_t        ctrl,
    input  logic            first_connect_event,
    input  logic            power_up_event,
    input  cfg_t            cfg,
    output logic [HS_W-1:0] hs_state,
    output logic [HS_W-1:0] hs_state_next
);

    logic [HS_W-1:0]    hs_reg, hs_next;
    logic [CNT16_W-1:0] wait_reg, wait_next;
    logic [CNT8_W-1:0]  fail_reg, fail_next;
    logic               conn_seen_reg, conn_seen_next;
    logic               pwr_seen_reg, pwr_seen_next;
    logic               conn_latched, pwr_latched;
    logic [CNT16_W-1:0] wait_inc;
    logic [CNT8_W-1:0]  fail_inc;

    assign conn_latched = first_connect_event | conn_seen_reg;
    assign pwr_latched  = power_up_event | (pwr_seen_reg & ~first_connect_event);
    assign wait_inc     = (wait_reg == CNT16_MAX) ? CNT16_MAX : wait_reg + 16'd1;
    assign fail_inc     = (fail_reg == CNT8_MAX) ? CNT8_MAX : fail_reg + 8'd1;

    always_comb
    begin
        hs_next        = hs_reg;
        wait_next      = wait_reg;
        fail_next      = fail_reg;
        conn_seen_next = conn_latched;
        pwr_seen_next  = pwr_latched;
        if (ctrl.tick)
        begin
            case (hs_reg)
                HS_START:
                begin
                    hs_next        = HS_WAIT_CONNECT;
                    wait_next      = '0;
                    conn_seen_next = 1'b0;
                end
                HS_WAIT_CONNECT:
                begin
                    wait_next = wait_inc;
                    if (wait_reg > cfg.first_connect_timeout)
                        hs_next = HS_ERROR;
                    if (conn_latched)
                        hs_next = HS_SEND_REQ;
                end
                HS_SEND_REQ:
                begin
                    wait_next = '0;
                    hs_next   = HS_WAIT_RESP;
                end
                HS_WAIT_RESP:
                begin
                    wait_next = wait_inc;
                    if (wait_reg > cfg.response_timeout)
                        hs_next = HS_ERROR;
                    if (pwr_latched)
                        hs_next = HS_DONE;
                end
                HS_ERROR:
                begin
                    hs_next   = HS_START;
                    fail_next = fail_inc;
                    if (fail_inc > cfg.retry_limit)
                    begin
                        fail_next = FAILED_MARK;
                        hs_next   = HS_FAILED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign hs_state      = hs_reg;
    assign hs_state_next = hs_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg        <= HS_START;
            wait_reg      <= '0;
            fail_reg      <= '0;
            conn_seen_reg <= 1'b0;
            pwr_seen_reg  <= 1'b0;
        end
        else if (ctrl.step)
        begin
            hs_reg        <= hs_next;
            wait_reg      <= wait_next;
            fail_reg      <= fail_next;
            conn_seen_reg <= conn_seen_next;
            pwr_seen_reg  <= pwr_seen_next;
        end
    end

    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (hs_reg == HS_FAILED) |=> (hs_reg == HS_FAILED))
        else $error("handshake left failed state");

    a_failed_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (hs_reg == HS_FAILED) |-> (fail_reg == FAILED_MARK))
        else $error("failed state without failure mark");

    a_tick_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.step) |=> $stable(hs_reg) && $stable(fail_reg))
        else $error("handshake moved without a step");

endmodule

>>> src/psup_watchdog.sv
// ----------------------------------------------------------------------------
// psup_watchdog
// Watchdog pin monitor: lost count, link error flag, soft reset request.
// ----------------------------------------------------------------------------
module psup_watchdog
    import psup_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  wd_ctrl_t        ctrl,
    input  logic            watchdog_pin,
    input  logic            processor_powered,
    input  logic            test_mode_normal,
    input  logic [VS_W-1:0] voltage_status,
    input  cfg_t            cfg,
    output logic            error_next,
    output logic            soft_reset
);

    logic               last_pin_reg, last_pin_next;
    logic [CNT16_W-1:0] lost_reg, lost_next;
    logic               error_reg;
    logic               pin_edge;
    logic [CNT16_W-1:0] lost_clr, lost_inc;

    assign pin_edge = watchdog_pin != last_pin_reg;
    assign lost_clr = pin_edge ? '0 : lost_reg;
    assign lost_inc = (lost_clr == CNT16_MAX) ? CNT16_MAX : lost_clr + 16'd1;

    always_comb
    begin
        last_pin_next = last_pin_reg;
        lost_next     = lost_reg;
        error_next    = error_reg;
        soft_reset    = 1'b0;
        if (ctrl.service)
        begin
            if (cfg.watchdog_enable && processor_powered)
            begin
                last_pin_next = watchdog_pin;
                lost_next     = lost_clr;
                if (pin_edge)
                    error_next = 1'b0;
                if (!test_mode_normal && voltage_status == VS_NORMAL)
                begin
                    lost_next = lost_inc;
                    if (lost_inc == cfg.watchdog_warn_count)
                        error_next = 1'b1;
                    if (lost_inc >= cfg.watchdog_timeout_count)
                        soft_reset = 1'b1;
                end
            end
            else
            begin
                lost_next = '0;
            end
        end
        else if (ctrl.clear)
        begin
            lost_next     = '0;
            last_pin_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pin_reg <= 1'b0;
            lost_reg     <= '0;
            error_reg    <= 1'b0;
        end
        else if (ctrl.step)
        begin
            last_pin_reg <= last_pin_next;
            lost_reg     <= lost_next;
            error_reg    <= error_next;
        end
    end

endmodule

>>> tb/soc_power_supervisor_top_test.sv
// ----------------------------------------------------------------------------
// soc_power_supervisor_top_test
// Drives tick words into the power supervisor under random input gaps and
// result stalls. A scoreboard class carries its own copy of the supply
// debounce, power sequencer, connect handshake and watchdog pin monitor.
// It predicts each status word and compares it field by field with the
// block's output. Register settings change between phases, only when the
// block has drained: defaults, short timeouts, all-high extremes, random
// settings and all-zero extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module soc_power_supervisor_top_test
    import psup_pkg::*;
();

    localparam logic [VS_W-1:0] VS_LOW   = 3'd2;
    localparam logic [VS_W-1:0] VS_OTHER = 3'd5;

    localparam logic [7:0] F_SLEEP = 8'h80;
    localparam logic [7:0] F_OFF   = 8'h40;
    localparam logic [7:0] F_FB    = 8'h20;
    localparam logic [7:0] F_CONN  = 8'h10;
    localparam logic [7:0] F_PUP   = 8'h08;
    localparam logic [7:0] F_PIN   = 8'h04;
    localparam logic [7:0] F_PWR   = 8'h02;
    localparam logic [7:0] F_TEST  = 8'h01;

    class supervisor_tracker;
        cfg_t               regs = CFG_DEFAULT;
        logic [SEQ_W-1:0]   seq = SEQ_IDLE;
        logic [HS_W-1:0]    hs = HS_START;
        logic [CNT16_W-1:0] wait_cnt = '0;
        logic [CNT16_W-1:0] lost = '0;
        logic [CNT8_W-1:0]  fail_cnt = '0;
        logic [CNT8_W-1:0]  norm_cnt = '0;
        logic [CNT8_W-1:0]  abn_cnt = '0;
        logic [CNT8_W-1:0]  high_cnt = '0;
        logic               pwr_ok = 1'b0;
        logic               link_ok = 1'b0;
        logic               conn_seen = 1'b0;
        logic               pup_seen = 1'b0;
        logic               pin_last = 1'b0;
        logic               err_flag = 1'b0;
        out_word_t          status_due[$];
        int                 mismatches = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_FIRST_CONNECT_TIMEOUT:  regs.first_connect_timeout = d;
                CFG_RESPONSE_TIMEOUT:       regs.response_timeout = d;
                CFG_RETRY_LIMIT:            regs.retry_limit = d[CNT8_W-1:0];
                CFG_VOLTAGE_DEBOUNCE:       regs.voltage_debounce = d[CNT8_W-1:0];
                CFG_HIGH_VOLTAGE_DEBOUNCE:  regs.high_voltage_debounce = d[CNT8_W-1:0];
                CFG_WATCHDOG_WARN_COUNT:    regs.watchdog_warn_count = d;
                CFG_WATCHDOG_TIMEOUT_COUNT: regs.watchdog_timeout_count = d;
                CFG_WATCHDOG_ENABLE:        regs.watchdog_enable = d[0];
                default: ;
            endcase
        endfunction

        function void qualify_supply(logic [VS_W-1:0] vs, logic sleep);
            if (vs == VS_NORMAL)
            begin
                if (norm_cnt != CNT8_MAX)
                    norm_cnt = norm_cnt + 1'b1;
                abn_cnt = '0;
                high_cnt = '0;
                if (norm_cnt > regs.voltage_debounce)
                begin
                    pwr_ok = !sleep;
                    link_ok = pwr_ok;
                    norm_cnt = regs.voltage_debounce + 1'b1;
                end
            end
            else if (vs >= VS_LOW_ABN && vs <= VS_HIGH_ABN)
            begin
                if (abn_cnt != CNT8_MAX)
                    abn_cnt = abn_cnt + 1'b1;
                norm_cnt = '0;
                high_cnt = '0;
                if (abn_cnt > regs.voltage_debounce)
                begin
                    pwr_ok = 1'b0;
                    link_ok = 1'b0;
                    abn_cnt = regs.voltage_debounce + 1'b1;
                end
            end
            else if (vs == VS_HIGH)
            begin
                if (high_cnt != CNT8_MAX)
                    high_cnt = high_cnt + 1'b1;
                abn_cnt = '0;
                norm_cnt = '0;
                if (high_cnt > regs.high_voltage_debounce)
                begin
                    pwr_ok = 1'b0;
                    link_ok = 1'b0;
                    high_cnt = regs.high_voltage_debounce + 1'b1;
                end
            end
        endfunction

        function void step_handshake();
            logic [CNT16_W-1:0] old;
            case (hs)
                HS_START:
                begin
                    hs = HS_WAIT_CONNECT;
                    wait_cnt = '0;
                    conn_seen = 1'b0;
                end
                HS_WAIT_CONNECT:
                begin
                    old = wait_cnt;
                    if (old != CNT16_MAX)
                        wait_cnt = old + 1'b1;
                    if (old > regs.first_connect_timeout)
                        hs = HS_ERROR;
                    if (conn_seen)
                        hs = HS_SEND_REQ;
                end
                HS_SEND_REQ:
                begin
                    wait_cnt = '0;
                    hs = HS_WAIT_RESP;
                end
                HS_WAIT_RESP:
                begin
                    old = wait_cnt;
                    if (old != CNT16_MAX)
                        wait_cnt = old + 1'b1;
                    if (old > regs.response_timeout)
                        hs = HS_ERROR;
                    if (pup_seen)
                        hs = HS_DONE;
                end
                HS_ERROR:
                begin
                    hs = HS_START;
                    if (fail_cnt != CNT8_MAX)
                        fail_cnt = fail_cnt + 1'b1;
                    if (fail_cnt > regs.retry_limit)
                    begin
                        fail_cnt = FAILED_MARK;
                        hs = HS_FAILED;
                    end
                end
                default: ;
            endcase
        endfunction

        function logic watch_pin(in_word_t w);
            logic soft_rst;
            logic prev;
            soft_rst = 1'b0;
            if (regs.watchdog_enable && w.processor_powered)
            begin
                prev = pin_last;
                pin_last = w.watchdog_pin;
                if (pin_last != prev)
                begin
                    lost = '0;
                    err_flag = 1'b0;
                end
                if (!w.test_mode_normal && w.voltage_status == VS_NORMAL)
                begin
                    if (lost != CNT16_MAX)
                        lost = lost + 1'b1;
                    if (lost == regs.watchdog_warn_count)
                        err_flag = 1'b1;
                    if (lost >= regs.watchdog_timeout_count)
                        soft_rst = 1'b1;
                end
            end
            else
                lost = '0;
            if (seq == SEQ_READY && hs == HS_DONE)
                seq = SEQ_CONNECTED;
            return soft_rst;
        endfunction

        function out_word_t advance_tick(in_word_t w);
            out_word_t        o;
            logic [CMD_W-1:0] pcmd;
            logic [CMD_W-1:0] lcmd;
            logic             linked;
            logic             soft_rst;
            logic             shut;
            logic             reinit;
            logic             was_ready;
            pcmd = PCMD_NONE;
            lcmd = LCMD_NONE;
            soft_rst = 1'b0;
            shut = 1'b0;
            reinit = 1'b0;
            if (w.first_connect_event)
            begin
                conn_seen = 1'b1;
                pup_seen = 1'b0;
            end
            if (w.power_up_event)
                pup_seen = 1'b1;
            linked = (hs == HS_DONE);
            qualify_supply(w.voltage_status, w.sleep_request);
            case (seq)
                SEQ_IDLE:
                begin
                    if (w.off_request)
                        seq = SEQ_POWER_OFF;
                    if (pwr_ok)
                    begin
                        pcmd = PCMD_ON;
                        seq = SEQ_POWER_ON;
                    end
                    else
                    begin
                        soft_rst = watch_pin(w);
                        if (w.device_power_feedback)
                            seq = SEQ_DEV_OFF;
                    end
                end
                SEQ_POWER_ON:
                begin
                    if (w.off_request)
                        seq = SEQ_POWER_OFF;
                    if (pwr_ok)
                    begin
                        if (link_ok)
                        begin
                            lcmd = LCMD_ENABLE;
                            seq = SEQ_READY;
                        end
                    end
                    else
                        seq = SEQ_DEV_OFF;
                end
                SEQ_READY, SEQ_CONNECTED:
                begin
                    was_ready = (seq == SEQ_READY);
                    if (w.off_request)
                        seq = SEQ_POWER_OFF;
                    if (!pwr_ok)
                        seq = SEQ_DEV_OFF;
                    else if (!link_ok)
                        seq = SEQ_POWER_ON;
                    else
                    begin
                        if (was_ready)
                            step_handshake();
                        soft_rst = watch_pin(w);
                    end
                end
                SEQ_POWER_OFF:
                begin
                    if (w.off_request)
                    begin
                        shut = 1'b1;
                        if (!pwr_ok)
                            seq = SEQ_DEV_OFF;
                    end
                    else
                    begin
                        reinit = 1'b1;
                        seq = SEQ_IDLE;
                    end
                end
                SEQ_DEV_OFF:
                begin
                    lost = '0;
                    pin_last = 1'b0;
                    lcmd = LCMD_DISABLE;
                    pcmd = PCMD_OFF;
                    seq = SEQ_IDLE;
                end
                default: ;
            endcase
            o.sequencer_state = seq;
            o.handshake_state = hs;
            o.link_connected = linked;
            o.power_allowed = pwr_ok;
            o.link_allowed = link_ok;
            o.power_command = pcmd;
            o.link_command = lcmd;
            o.shutdown_pulse = shut;
            o.reinit_pulse = reinit;
            o.link_error = err_flag;
            o.soft_reset_request = soft_rst;
            return o;
        endfunction

        function void take_tick(in_word_t w);
            status_due.push_back(advance_tick(w));
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        endfunction

        function void match_status(out_word_t got);
            out_word_t want;
            if (status_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: status word expected none actual %0h", $time, got);
                return;
            end
            want = status_due.pop_front();
            if (got.sequencer_state !== want.sequencer_state)
                report("sequencer_state", want.sequencer_state, got.sequencer_state);
            if (got.handshake_state !== want.handshake_state)
                report("handshake_state", want.handshake_state, got.handshake_state);
            if (got.link_connected !== want.link_connected)
                report("link_connected", want.link_connected, got.link_connected);
            if (got.power_allowed !== want.power_allowed)
                report("power_allowed", want.power_allowed, got.power_allowed);
            if (got.link_allowed !== want.link_allowed)
                report("link_allowed", want.link_allowed, got.link_allowed);
            if (got.power_command !== want.power_command)
                report("power_command", want.power_command, got.power_command);
            if (got.link_command !== want.link_command)
                report("link_command", want.link_command, got.link_command);
            if (got.shutdown_pulse !== want.shutdown_pulse)
                report("shutdown_pulse", want.shutdown_pulse, got.shutdown_pulse);
            if (got.reinit_pulse !== want.reinit_pulse)
                report("reinit_pulse", want.reinit_pulse, got.reinit_pulse);
            if (got.link_error !== want.link_error)
                report("link_error", want.link_error, got.link_error);
            if (got.soft_reset_request !== want.soft_reset_request)
                report("soft_reset_request", want.soft_reset_request,
                       got.soft_reset_request);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_word_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;

    bit                    gaps_on = 1'b1;
    logic                  pin_level = 1'b0;
    supervisor_tracker     board = new();

    soc_power_supervisor_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("soc_power_supervisor_top_test failed");
        $finish;
    end

    function automatic bit pct(int p);
        return $urandom_range(0, 99) < p;
    endfunction

    function automatic in_word_t make_word(logic [VS_W-1:0] vs, logic [7:0] flags);
        return {vs, flags};
    endfunction

    function automatic cfg_t random_settings(int retry_lo);
        cfg_t s;
        s.first_connect_timeout = CNT16_W'($urandom_range(0, 40));
        s.response_timeout = CNT16_W'($urandom_range(0, 40));
        s.retry_limit = CNT8_W'($urandom_range(retry_lo, 254));
        s.voltage_debounce = CNT8_W'($urandom_range(0, 6));
        s.high_voltage_debounce = CNT8_W'($urandom_range(0, 6));
        s.watchdog_warn_count = CNT16_W'($urandom_range(0, 20));
        s.watchdog_timeout_count = CNT16_W'($urandom_range(0, 40));
        s.watchdog_enable = ($urandom_range(0, 4) != 0);
        return s;
    endfunction

    always @(posedge clk)
    begin
        out_stall <= gaps_on && pct(26);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.take_tick(in_data);
            if (out_valid && !out_stall)
                board.match_status(out_data);
        end
    end

    task automatic send_word(input in_word_t w);
        while (gaps_on && pct(26))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.status_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        board.set_reg(idx, d);
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(CFG_FIRST_CONNECT_TIMEOUT, s.first_connect_timeout);
        write_reg(CFG_RESPONSE_TIMEOUT, s.response_timeout);
        write_reg(CFG_RETRY_LIMIT, CFG_DATA_W'(s.retry_limit));
        write_reg(CFG_VOLTAGE_DEBOUNCE, CFG_DATA_W'(s.voltage_debounce));
        write_reg(CFG_HIGH_VOLTAGE_DEBOUNCE, CFG_DATA_W'(s.high_voltage_debounce));
        write_reg(CFG_WATCHDOG_WARN_COUNT, s.watchdog_warn_count);
        write_reg(CFG_WATCHDOG_TIMEOUT_COUNT, s.watchdog_timeout_count);
        write_reg(CFG_WATCHDOG_ENABLE, CFG_DATA_W'(s.watchdog_enable));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int pup_pct, input int pin_pct);
        in_word_t w;
        int       off_left;
        int       r;
        off_left = 0;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 84)
                w.voltage_status = VS_NORMAL;
            else if (r < 90)
                w.voltage_status = VS_W'($urandom_range(VS_LOW_ABN, VS_HIGH_ABN));
            else if (r < 95)
                w.voltage_status = VS_HIGH;
            else
                w.voltage_status = VS_W'($urandom_range(VS_OTHER, 7));
            // hold off requests for a few ticks so shutdown is reached
            if (off_left == 0 && pct(3))
                off_left = $urandom_range(1, 4);
            w.off_request = (off_left != 0);
            if (off_left != 0)
                off_left--;
            if (pct(pin_pct))
                pin_level = ~pin_level;
            w.sleep_request = pct(3);
            w.device_power_feedback = pct(6);
            w.first_connect_event = pct(6);
            w.power_up_event = pct(pup_pct);
            w.watchdog_pin = pin_level;
            w.processor_powered = !pct(8);
            w.test_mode_normal = pct(5);
            send_word(w);
        end
        drain();
    endtask

    initial
    begin
        cfg_t s;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: field extremes, every voltage class, both events at once
        send_word(make_word(VS_NORMAL, '0));
        send_word(make_word('1, '1));
        send_word(make_word(VS_HIGH, F_CONN | F_PUP));
        send_word(make_word(VS_LOW_ABN, F_PIN | F_PWR));
        send_word(make_word(VS_HIGH_ABN, F_SLEEP));
        send_word(make_word(VS_LOW, F_OFF));
        send_word(make_word(VS_OTHER, F_FB));
        drain();

        // short timeouts: power up, connect timeout and retry, watchdog warn
        // and soft reset, pin edge, off request, high voltage, device off
        s = '{16'd2, 16'd1, 8'd254, 8'd0, 8'd1, 16'd2, 16'd3, 1'b1};
        apply_settings(s);
        repeat (7) send_word(make_word(VS_NORMAL, F_PWR));
        send_word(make_word(VS_NORMAL, F_PWR | F_CONN));
        repeat (2) send_word(make_word(VS_NORMAL, F_PWR));
        send_word(make_word(VS_NORMAL, F_PWR | F_PIN));
        send_word(make_word(VS_NORMAL, F_PWR | F_PIN | F_TEST));
        repeat (2) send_word(make_word(VS_NORMAL, F_PWR | F_OFF));
        send_word(make_word(VS_NORMAL, F_PWR));
        repeat (2) send_word(make_word(VS_HIGH, F_PWR));
        send_word(make_word(VS_LOW, F_FB));
        drain();

        // all-high extremes; a debounce of 255 never qualifies
        s = '{16'hFFFF, 16'hFFFF, 8'd254, 8'd255, 8'd254, 16'hFFFF, 16'hFFFF, 1'b1};
        apply_settings(s);
        run_phase(40, 2, 5);

        for (int p = 0; p < 6; p++)
        begin
            apply_settings(random_settings(p < 4 ? 200 : 0));
            gaps_on <= (p != 2);
            run_phase(150, p < 4 ? 0 : 5, $urandom_range(2, 15));
        end
        gaps_on <= 1'b1;

        apply_settings('0);
        run_phase(90, 6, 10);

        if (board.mismatches == 0 && board.status_due.size() == 0)
            $display("soc_power_supervisor_top_test passed");
        else
            $display("soc_power_supervisor_top_test failed");
        $finish;
    end

endmodule
